// ===== hw/rtl/fdl_pkg.sv =====
`default_nettype none
package fdl_pkg;

  localparam int unsigned FRAME_LEN   = 57;
  localparam int unsigned PAYLOAD_LEN = FRAME_LEN - 5;
  localparam int unsigned POS_W       = $clog2(FRAME_LEN);
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] POS_M2   = POS_W'(FRAME_LEN - 2);
  localparam logic [POS_W-1:0] POS_M3   = POS_W'(FRAME_LEN - 3);
  localparam logic [POS_W-1:0] BASE_A   = POS_W'(3);
  localparam logic [POS_W-1:0] BASE_B   = POS_W'(2);
  localparam logic [POS_W-1:0] PAY_SPAN = POS_W'(PAYLOAD_LEN - 1);

  localparam logic [7:0] CHR_H  = 8'h48;
  localparam logic [7:0] CHR_D  = 8'h44;
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;

  localparam logic [3:0] GOOD_MAX = 4'd15;
  localparam logic [7:0] HB_MAX   = 8'd255;

  localparam logic [3:0] START_COUNT_RST = 4'd10;
  localparam logic [7:0] LOST_LIMIT_RST  = 8'd20;

  typedef enum logic [0:0] {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_REJECT  = 2'd1,
    KIND_TICK    = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_COUNT = 1'b0,
    CFG_LOST_LIMIT  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       good;
    logic       tick;
    logic [7:0] plan_byte;
  } evt_t;

  typedef struct packed {
    logic started;
    logic lost;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fdl_if.sv =====
`default_nettype none
interface fdl_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface fdl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       last;
  logic       link_started;
  logic       link_lost;

  modport source (output valid, output kind, output payload_byte, output last,
                  output link_started, output link_lost, input ready);
  modport sink   (input valid, input kind, input payload_byte, input last,
                  input link_started, input link_lost, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/frame_deframer_link_watchdog_unit.sv =====
// Link deframer with heartbeat watchdog. Each input word is a received link
// byte or a timer tick. Bytes are written one per cycle into a frame RAM while
// the block is idle and produce nothing until the last byte of a frame. The
// final byte leads to a frame check in the CHECK state, then to either one
// reject word or the payload words read back from the RAM, each payload word
// through a registered RAM read (WAIT) and then a load of the output register
// (DRAIN). Input stays blocked until the reject word or the last payload word
// of a good frame is loaded, and for as long as the output is stalled. A tick
// updates the watchdog at once and yields one status word, loaded from the
// EMIT state once the output register is free. Every result word carries the
// link started and link lost flags as they stand after the input that caused
// it. Configuration is taken on any cycle with cfg_we_i high and must be
// written only while the block is idle.
`default_nettype none
module frame_deframer_link_watchdog_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fdl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fdl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  fdl_in_if.sink                               in_if,
  fdl_out_if.source                            out_if
);
  import fdl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_WAIT,
    ST_DRAIN
  } state_e;

  state_e           state_q;
  logic [POS_W-1:0] pos_q;
  logic [7:0]       hdr0_q, hdr1_q, hdr2_q, hdr3_q, hdr4_q;
  logic [7:0]       hdr_m3_q, hdr_m2_q, hdr_last_q;
  logic [1:0]       pend_kind_q;
  logic [POS_W-1:0] rd_addr_q;
  logic [POS_W-1:0] end_addr_q;
  logic [3:0]       start_count_q;
  logic [7:0]       lost_limit_q;

  logic             out_valid_q;
  logic [1:0]       out_kind_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;
  logic             out_started_q;
  logic             out_lost_q;

  logic             in_fire;
  logic             slot_free;
  logic             out_load;
  logic             match_a;
  logic             match_b;
  logic             frame_good;
  logic [POS_W-1:0] base;
  logic             rd_en;
  logic [POS_W-1:0] rd_addr_d;
  logic [7:0]       rd_data;
  logic             drain_last;
  evt_t             evt;
  status_t          status;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign slot_free   = !out_valid_q || out_if.ready;
  assign out_load    = ((state_q == ST_EMIT) || (state_q == ST_DRAIN)) && slot_free;

  assign match_a = (hdr1_q == CHR_H) && (hdr2_q == CHR_D) &&
                   (hdr_m2_q == CHR_CR) && (hdr_last_q == CHR_LF);
  assign match_b = (hdr0_q == CHR_H) && (hdr1_q == CHR_D) &&
                   (hdr_m3_q == CHR_CR) && (hdr_m2_q == CHR_LF);
  assign frame_good = match_a || match_b;
  assign base       = match_a ? BASE_A : BASE_B;
  assign drain_last = (rd_addr_q == end_addr_q);

  always_comb begin
    rd_en     = 1'b0;
    rd_addr_d = rd_addr_q;
    if (state_q == ST_CHECK && frame_good) begin
      rd_en     = 1'b1;
      rd_addr_d = base;
    end else if (state_q == ST_DRAIN && slot_free && !drain_last) begin
      rd_en     = 1'b1;
      rd_addr_d = rd_addr_q + POS_W'(1);
    end
  end

  always_comb begin
    evt.good      = (state_q == ST_CHECK) && frame_good;
    evt.tick      = in_fire && (in_if.command == CMD_TICK);
    evt.plan_byte = match_a ? hdr4_q : hdr3_q;
  end

  fdl_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_LEN)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_if.command == CMD_BYTE)),
    .waddr_i (pos_q),
    .wdata_i (in_if.rx_byte),
    .re_i    (rd_en),
    .raddr_i (rd_addr_d),
    .rdata_o (rd_data)
  );

  fdl_watch u_watch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_i         (evt),
    .start_count_i (start_count_q),
    .lost_limit_i  (lost_limit_q),
    .status_o      (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_count_q <= START_COUNT_RST;
      lost_limit_q  <= LOST_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_COUNT: start_count_q <= cfg_data_i[3:0];
        CFG_LOST_LIMIT:  lost_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // header and trailer bytes are kept aside for the frame check
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_if.command == CMD_BYTE)) begin
      if (pos_q == POS_W'(0)) hdr0_q     <= in_if.rx_byte;
      if (pos_q == POS_W'(1)) hdr1_q     <= in_if.rx_byte;
      if (pos_q == POS_W'(2)) hdr2_q     <= in_if.rx_byte;
      if (pos_q == POS_W'(3)) hdr3_q     <= in_if.rx_byte;
      if (pos_q == POS_W'(4)) hdr4_q     <= in_if.rx_byte;
      if (pos_q == POS_M3)    hdr_m3_q   <= in_if.rx_byte;
      if (pos_q == POS_M2)    hdr_m2_q   <= in_if.rx_byte;
      if (pos_q == POS_LAST)  hdr_last_q <= in_if.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pos_q         <= '0;
      out_valid_q   <= 1'b0;
      pend_kind_q   <= KIND_PAYLOAD;
      rd_addr_q     <= '0;
      end_addr_q    <= '0;
      out_kind_q    <= KIND_PAYLOAD;
      out_byte_q    <= '0;
      out_last_q    <= 1'b0;
      out_started_q <= 1'b0;
      out_lost_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_if.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      rd_addr_q <= rd_addr_d;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_if.command == CMD_TICK) begin
              pend_kind_q <= KIND_TICK;
              state_q     <= ST_EMIT;
            end else if (pos_q == POS_LAST) begin
              pos_q   <= '0;
              state_q <= ST_CHECK;
            end else begin
              pos_q <= pos_q + POS_W'(1);
            end
          end
        end
        ST_CHECK: begin
          if (frame_good) begin
            end_addr_q <= base + PAY_SPAN;
            state_q    <= ST_WAIT;
          end else begin
            pend_kind_q <= KIND_REJECT;
            state_q     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_q   <= 1'b1;
            out_kind_q    <= pend_kind_q;
            out_byte_q    <= 8'd0;
            out_last_q    <= 1'b1;
            out_started_q <= status.started;
            out_lost_q    <= status.lost;
            state_q       <= ST_IDLE;
          end
        end
        ST_WAIT: begin
          state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (slot_free) begin
            out_valid_q   <= 1'b1;
            out_kind_q    <= KIND_PAYLOAD;
            out_byte_q    <= rd_data;
            out_last_q    <= drain_last;
            out_started_q <= status.started;
            out_lost_q    <= status.lost;
            state_q       <= drain_last ? ST_IDLE : ST_WAIT;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.kind         = out_kind_q;
  assign out_if.payload_byte = out_byte_q;
  assign out_if.last         = out_last_q;
  assign out_if.link_started = out_started_q;
  assign out_if.link_lost    = out_lost_q;

endmodule
`default_nettype wire

// ===== hw/rtl/fdl_ram.sv =====
`default_nettype none
module fdl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fdl_watch.sv =====
`default_nettype none
module fdl_watch (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire fdl_pkg::evt_t   evt_i,
  input  wire logic [3:0]      start_count_i,
  input  wire logic [7:0]      lost_limit_i,
  output fdl_pkg::status_t     status_o
);
  import fdl_pkg::*;

  logic [3:0] good_cnt_q;
  logic [3:0] good_sat;
  logic       started_q;
  logic [7:0] hb_q;
  logic [7:0] hb_sat;
  logic       lost_q;
  logic [7:0] plan_q;

  assign good_sat = (good_cnt_q < GOOD_MAX) ? good_cnt_q + 4'd1 : good_cnt_q;
  assign hb_sat   = (hb_q < HB_MAX) ? hb_q + 8'd1 : hb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_cnt_q <= '0;
      started_q  <= 1'b0;
      hb_q       <= '0;
      lost_q     <= 1'b0;
      plan_q     <= '0;
    end else if (evt_i.good) begin
      // hold the count one above the threshold once started
      if (good_sat > start_count_i) begin
        started_q  <= 1'b1;
        good_cnt_q <= start_count_i + 4'd1;
      end else begin
        good_cnt_q <= good_sat;
      end
      hb_q   <= '0;
      plan_q <= evt_i.plan_byte;
    end else if (evt_i.tick && started_q && (plan_q == 8'd0)) begin
      hb_q <= hb_sat;
      if (hb_sat > lost_limit_i) begin
        lost_q <= 1'b1;
      end
    end
  end

  assign status_o.started = started_q;
  assign status_o.lost    = lost_q;

endmodule
`default_nettype wire

// ===== hw/rtl/fdl_chk.sv =====
`default_nettype none
module fdl_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] out_kind_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i,
  input wire logic       out_lost_i
);
  import fdl_pkg::*;

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_byte_i) &&
                                       $stable(out_kind_i) && $stable(out_last_i)))
    else $error("stalled output word changed");

  // reject and tick words stand alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_kind_i == KIND_REJECT || out_kind_i == KIND_TICK)) |-> out_last_i)
    else $error("single result word without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_kind_i != KIND_PAYLOAD) |-> (out_byte_i == 8'd0))
    else $error("non-payload word carries data");

  // lost never clears once reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_lost_i) |=> (!out_valid_i || out_lost_i))
    else $error("link lost flag dropped");

endmodule

bind frame_deframer_link_watchdog_unit fdl_chk u_fdl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_kind_i  (out_if.kind),
  .out_byte_i  (out_if.payload_byte),
  .out_last_i  (out_if.last),
  .out_lost_i  (out_if.link_lost)
);
`default_nettype wire
